@@ design/gsp_pkg.sv @@
package gsp_pkg;

    // Poll frame geometry
    localparam int unsigned POLL_BYTES = 5;
    localparam int unsigned POLL_BITS  = 40;
    localparam int unsigned BIT_IDX_W  = 6;

    // Byte slots that carry the button bytes
    localparam logic [2:0] BYTE_BTN_LOW  = 3'd3;
    localparam logic [2:0] BYTE_BTN_HIGH = 3'd4;
    localparam logic [2:0] BIT_LAST      = 3'd7;
    localparam logic [BIT_IDX_W-1:0] BIT_IDX_LAST = 6'd39;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
    localparam logic [7:0]  BTN_RELEASED      = 8'hFF;

    // Command bytes shifted out during one poll
    localparam logic [7:0] CMD_BYTES [POLL_BYTES] = '{8'h01, 8'h42, 8'h00, 8'h00, 8'h00};

    typedef struct packed {
        logic        busy_res;
        logic        poll_done;
        logic [15:0] buttons_pressed;
        logic        clk_level;
        logic        cmd_level;
        logic        att_level;
    } result_t;

    // Command bit for a byte slot and a bit position, zero beyond the frame
    function automatic logic cmd_bit(input logic [2:0] byte_i, input logic [2:0] bit_i);
        logic [7:0] cbyte;
        cbyte = 8'h00;
        if (byte_i < 3'(POLL_BYTES)) begin
            cbyte = CMD_BYTES[byte_i];
        end
        return cbyte[bit_i];
    endfunction

endpackage

@@ design/gsp_core.sv @@
module gsp_core #(
    parameter int unsigned TICK_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic                    start_req,
    input  logic                    data_in,
    input  logic [15:0]             half_period,
    output gsp_pkg::result_t        result
);
    import gsp_pkg::*;

    localparam int unsigned CMP_W = (TICK_BITS > 16) ? TICK_BITS : 16;

    logic                  active_reg, active_next;
    logic [BIT_IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [TICK_BITS-1:0]  tick_count_reg, tick_count_next;
    logic                  high_half_reg, high_half_next;
    logic [7:0]            shift_in_reg, shift_in_next;
    logic [7:0]            btn_low_reg, btn_low_next;
    logic [7:0]            btn_high_reg, btn_high_next;

    logic                  launch;
    logic                  run;
    logic [BIT_IDX_W-1:0]  bit_cur;
    logic [TICK_BITS-1:0]  tick_cur;
    logic                  high_cur;
    logic [7:0]            shift_cur;
    logic [15:0]           half_m1;
    logic                  half_end;
    logic [2:0]            byte_i;
    logic [2:0]            bit_i;

    // Start a poll only from idle; the start tick is the first low-half tick
    assign launch    = !active_reg && start_req;
    assign run       = active_reg || start_req;
    assign bit_cur   = launch ? '0 : bit_index_reg;
    assign tick_cur  = launch ? '0 : tick_count_reg;
    assign high_cur  = launch ? 1'b0 : high_half_reg;
    assign shift_cur = launch ? 8'h00 : shift_in_reg;
    assign byte_i    = bit_cur[5:3];
    assign bit_i     = bit_cur[2:0];

    // Half ends at period-1; zero counts as one, and the counter ceiling clamps it
    assign half_m1  = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;
    assign half_end = (CMP_W'(tick_cur) >= CMP_W'(half_m1)) || (tick_cur == '1);

    // Advance the bit sequencer and build the tick's result
    always_comb begin
        active_next     = active_reg;
        bit_index_next  = bit_index_reg;
        tick_count_next = tick_count_reg;
        high_half_next  = high_half_reg;
        shift_in_next   = shift_in_reg;
        btn_low_next    = btn_low_reg;
        btn_high_next   = btn_high_reg;
        result          = '0;
        result.att_level = 1'b1;
        result.cmd_level = 1'b1;
        result.clk_level = 1'b1;

        if (run) begin
            result.att_level = 1'b0;
            result.busy_res  = 1'b1;
            result.cmd_level = cmd_bit(byte_i, bit_i);
            result.clk_level = high_cur;
            active_next      = 1'b1;
            bit_index_next   = bit_cur;
            high_half_next   = high_cur;
            shift_in_next    = shift_cur;

            if (!half_end) begin
                tick_count_next = tick_cur + TICK_BITS'(1);
            end else begin
                tick_count_next = '0;
                if (!high_cur) begin
                    // Sample data on the last low-half tick
                    shift_in_next[bit_i] = shift_cur[bit_i] | data_in;
                    high_half_next       = 1'b1;
                end else begin
                    high_half_next = 1'b0;
                    if (bit_i == BIT_LAST) begin
                        if (byte_i == BYTE_BTN_LOW) begin
                            btn_low_next = shift_cur;
                        end else if (byte_i == BYTE_BTN_HIGH) begin
                            btn_high_next = shift_cur;
                        end
                        shift_in_next = 8'h00;
                    end
                    if (bit_cur == BIT_IDX_LAST) begin
                        bit_index_next   = '0;
                        active_next      = 1'b0;
                        result.poll_done = 1'b1;
                    end else begin
                        bit_index_next = bit_cur + BIT_IDX_W'(1);
                    end
                end
            end
        end
        result.buttons_pressed = ~{btn_high_next, btn_low_next};
    end

    // Hold sequencer state between accepted ticks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            bit_index_reg  <= '0;
            tick_count_reg <= '0;
            high_half_reg  <= 1'b0;
            shift_in_reg   <= 8'h00;
            btn_low_reg    <= BTN_RELEASED;
            btn_high_reg   <= BTN_RELEASED;
        end else if (step_en) begin
            active_reg     <= active_next;
            bit_index_reg  <= bit_index_next;
            tick_count_reg <= tick_count_next;
            high_half_reg  <= high_half_next;
            shift_in_reg   <= shift_in_next;
            btn_low_reg    <= btn_low_next;
            btn_high_reg   <= btn_high_next;
        end
    end

    a_done_ends_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && result.poll_done) |=> !active_reg)
        else $error("poll still active after done tick");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> (bit_index_reg == '0 && tick_count_reg == '0 && !high_half_reg))
        else $error("sequencer not parked while idle");

    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_index_reg <= BIT_IDX_LAST)
        else $error("bit index beyond frame");

endmodule

@@ design/gsp_out_stage.sv @@
module gsp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  gsp_pkg::result_t  in_result,
    output logic              out_valid,
    input  logic              out_ready,
    output gsp_pkg::result_t  out_result
);
    import gsp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // Take a new request whenever the held result leaves or none is held
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_valid || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on accept
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |-> !in_ready)
        else $error("request accepted over a stalled result");

endmodule

@@ design/gamepad_serial_poller_top.sv @@
// A result appears on m_tvalid in the cycle after its tick is accepted.
// One tick per cycle while results are taken; a stalled result holds s_tready low. The bit
// sequencer advances once per accepted tick and the output register frees as the result is taken.
// Reset: aresetn synchronous active low; sequencer idle, buttons read as released,
// half period returns to 50 ticks, output register empty.
module gamepad_serial_poller_top #(
    parameter int unsigned TICK_COUNTER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_req, [1] data_in, [7:2] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] att_level, [1] cmd_level, [2] clk_level,
                                   // [18:3] buttons_pressed, [19] busy_res, [23:20] zero
    output logic        m_tlast,   // poll_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // half_period_ticks
);
    import gsp_pkg::*;

    logic [15:0] half_period_reg;
    logic        step_en;
    result_t     step_result;
    result_t     out_result;

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            half_period_reg <= cfg_data;
        end
    end

    assign step_en = s_tvalid && s_tready;

    gsp_core #(
        .TICK_BITS (TICK_COUNTER_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .start_req   (s_tdata[0]),
        .data_in     (s_tdata[1]),
        .half_period (half_period_reg),
        .result      (step_result)
    );

    gsp_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_result  (step_result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    // Pack the result onto the stream
    assign m_tdata = {4'b0000, out_result.busy_res, out_result.buttons_pressed,
                      out_result.clk_level, out_result.cmd_level, out_result.att_level};
    assign m_tlast = out_result.poll_done;

endmodule

@@ tb/gamepad_serial_poller_checker.sv @@
module gamepad_serial_poller_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_req, [1] data_in, [7:2] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [0] att_level, [1] cmd_level, [2] clk_level,
                                   // [18:3] buttons_pressed, [19] busy_res, [23:20] zero
    input  logic        m_tlast,   // poll_done
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,  // half_period_ticks
    output int          err_count,
    output int          exp_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import gsp_pkg::*;

    // Shadow of the poller sequencer and its register
    logic [15:0]          half_ticks;
    logic                 poll_on;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic [15:0]          tick_cnt;
    logic                 high_half;
    logic [7:0]           shift_byte;
    logic [7:0]           btn_lo_raw;
    logic [7:0]           btn_hi_raw;

    result_t pin_expect_q[$];
    int      n_err = 0;

    // Advance the shadow sequencer by one tick and return the pin levels it shows
    task automatic poll_tick(input logic start, input logic din, output result_t r);
        logic [2:0]  byte_i;
        logic [2:0]  bit_i;
        logic [7:0]  cbyte;
        logic [16:0] eff_half;
        logic        half_end;

        if (!poll_on && start) begin
            poll_on    = 1'b1;
            bit_idx    = '0;
            tick_cnt   = '0;
            high_half  = 1'b0;
            shift_byte = '0;
        end

        r.att_level = 1'b1;
        r.cmd_level = 1'b1;
        r.clk_level = 1'b1;
        r.poll_done = 1'b0;
        r.busy_res  = 1'b0;

        if (poll_on) begin
            byte_i   = bit_idx[5:3];
            bit_i    = bit_idx[2:0];
            cbyte    = (byte_i < 3'(POLL_BYTES)) ? CMD_BYTES[byte_i] : 8'h00;
            // a zero half period behaves as one tick
            eff_half = (half_ticks == 16'd0) ? 17'd1 : {1'b0, half_ticks};
            half_end = ({1'b0, tick_cnt} >= eff_half - 17'd1);

            r.busy_res  = 1'b1;
            r.att_level = 1'b0;
            r.cmd_level = cbyte[bit_i];
            r.clk_level = high_half;

            if (!half_end) begin
                tick_cnt = tick_cnt + 16'd1;
            end else begin
                tick_cnt = '0;
                if (!high_half) begin
                    // sample the pad on the last tick of the low half
                    if (din) begin
                        shift_byte[bit_i] = 1'b1;
                    end
                    high_half = 1'b1;
                end else begin
                    high_half = 1'b0;
                    if (bit_i == BIT_LAST) begin
                        if (byte_i == BYTE_BTN_LOW) begin
                            btn_lo_raw = shift_byte;
                        end else if (byte_i == BYTE_BTN_HIGH) begin
                            btn_hi_raw = shift_byte;
                        end
                        shift_byte = '0;
                    end
                    bit_idx = bit_idx + BIT_IDX_W'(1);
                    if (bit_idx >= BIT_IDX_W'(POLL_BITS)) begin
                        bit_idx     = '0;
                        poll_on     = 1'b0;
                        r.poll_done = 1'b1;
                    end
                end
            end
        end

        r.buttons_pressed = ~{btn_hi_raw, btn_lo_raw};
    endtask

    // Watch the three channels: take config writes, compare results, then predict new requests
    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;

        if (!aresetn) begin
            half_ticks = HALF_PERIOD_RESET;
            poll_on    = 1'b0;
            bit_idx    = '0;
            tick_cnt   = '0;
            high_half  = 1'b0;
            shift_byte = '0;
            btn_lo_raw = BTN_RELEASED;
            btn_hi_raw = BTN_RELEASED;
            pin_expect_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                half_ticks = cfg_data;
            end

            if (m_tvalid && m_tready) begin
                got.att_level       = m_tdata[0];
                got.cmd_level       = m_tdata[1];
                got.clk_level       = m_tdata[2];
                got.buttons_pressed = m_tdata[18:3];
                got.busy_res        = m_tdata[19];
                got.poll_done       = m_tlast;
                if (pin_expect_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("[%0t] result with nothing pending: tdata=%h tlast=%b",
                                 $time, m_tdata, m_tlast);
                    end
                end else begin
                    want = pin_expect_q.pop_front();
                    if (got.att_level !== want.att_level ||
                        got.cmd_level !== want.cmd_level ||
                        got.clk_level !== want.clk_level ||
                        got.buttons_pressed !== want.buttons_pressed ||
                        got.poll_done !== want.poll_done ||
                        got.busy_res !== want.busy_res) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display({"[%0t] pin mismatch: expected att=%b cmd=%b clk=%b ",
                                      "btn=%h done=%b busy=%b, got att=%b cmd=%b clk=%b ",
                                      "btn=%h done=%b busy=%b"}, $time,
                                     want.att_level, want.cmd_level, want.clk_level,
                                     want.buttons_pressed, want.poll_done, want.busy_res,
                                     got.att_level, got.cmd_level, got.clk_level,
                                     got.buttons_pressed, got.poll_done, got.busy_res);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                poll_tick(s_tdata[0], s_tdata[1], want);
                pin_expect_q.push_back(want);
            end
        end

        err_count   <= n_err;
        exp_pending <= pin_expect_q.size();
    end

endmodule

@@ tb/gamepad_serial_poller_top_tb.sv @@
module gamepad_serial_poller_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RUN_LIMIT    = 300000;
    localparam int TAIL_CYCLES  = 4;
    localparam int PHASE_TICKS  = 230;
    localparam int OPEN_TICKS   = 150;

    // Pad data pattern held through one poll
    typedef enum int {
        DATA_RANDOM,
        DATA_LOW,
        DATA_HIGH
    } data_pat_e;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [0] start_req, [1] data_in, [7:2] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // [0] att_level, [1] cmd_level, [2] clk_level,
                                   // [18:3] buttons_pressed, [19] busy_res, [23:20] zero
    logic        m_tlast;          // poll_done
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;   // half_period_ticks

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycles         = 0;
    int err_count;
    int exp_pending;

    gamepad_serial_poller_top #(
        .TICK_COUNTER_BITS(16)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    gamepad_serial_poller_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .err_count   (err_count),
        .exp_pending (exp_pending)
    );

    always #CLK_HALF_NS aclk = ~aclk;

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Give up if the run hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Send one tick request, with random idle cycles ahead of it
    task automatic send_tick(input logic start, input logic din);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, din, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_half_period(input logic [15:0] ticks);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold off until every pending result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (exp_pending != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Full polls separated by short idle runs; extra starts inside a poll are ignored
    task automatic run_polls(input logic [15:0] half, input int unsigned n_ticks);
        int unsigned sent;
        int unsigned poll_len;
        data_pat_e   pat;
        logic        din;

        sent     = 0;
        poll_len = gsp_pkg::POLL_BITS * 2 * ((half == 16'd0) ? 1 : half);
        while (sent < n_ticks) begin
            repeat ($urandom_range(0, 3)) begin
                send_tick(1'b0, 1'($urandom_range(0, 1)));
                sent++;
            end
            pat = data_pat_e'($urandom_range(0, 2));
            for (int i = 0; i < poll_len; i++) begin
                case (pat)
                    DATA_LOW:  din = 1'b0;
                    DATA_HIGH: din = 1'b1;
                    default:   din = 1'($urandom_range(0, 1));
                endcase
                send_tick((i == 0) ? 1'b1 : 1'($urandom_range(0, 1)), din);
            end
            sent += poll_len;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Idle ticks, then the opening bits of a poll at the reset half period with
        // the pad held low; start is repeated while busy
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        for (int i = 0; i < OPEN_TICKS; i++) begin
            send_tick(1'((i % 3) == 0), 1'b0);
        end

        // Zero half period behaves as one tick; the open poll finishes at the new rate
        drain();
        write_half_period(16'd0);
        run_polls(16'd0, PHASE_TICKS);

        drain();
        src_idle_pct = 82;
        write_half_period(16'd1);
        run_polls(16'd1, PHASE_TICKS);

        drain();
        src_idle_pct   = 0;
        sink_stall_pct = 82;
        write_half_period(16'd2);
        run_polls(16'd2, PHASE_TICKS);

        drain();
        src_idle_pct   = 35;
        sink_stall_pct = 35;
        write_half_period(16'd3);
        run_polls(16'd3, PHASE_TICKS);

        // Largest half period: only the start of a poll fits in the run
        drain();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_half_period(16'hFFFF);
        for (int i = 0; i < 160; i++) begin
            send_tick((i == 4) || (i > 4 && $urandom_range(0, 1) == 1),
                      1'($urandom_range(0, 1)));
        end

        drain();
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/gsp_pkg.sv
design/gsp_core.sv
design/gsp_out_stage.sv
design/gamepad_serial_poller_top.sv
tb/gamepad_serial_poller_checker.sv
tb/gamepad_serial_poller_top_tb.sv
